FILE: rtl/smng_pkg.sv
// ----------------------------------------------------------------------------
// smng_pkg
// Shared constants, codes and index helpers for the second-order Markov
// note generator.
// ----------------------------------------------------------------------------
package smng_pkg;

    // sizes
    localparam int MAX_NOTES = 16;
    localparam int RAND_BITS = 16;
    localparam int IDX_W     = $clog2(MAX_NOTES);
    localparam int HIST_W    = 2 * IDX_W;
    localparam int CNT_AW    = 3 * IDX_W;
    localparam int CNT_W     = 32;
    localparam int SIZE_W    = 5;
    localparam int OFS_W     = 8;
    localparam int NOTE_W    = 9;
    localparam int KIND_W    = 2;
    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd2;

    // command kinds
    localparam logic [KIND_W-1:0] KIND_NOTE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_GEN   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    // alphabet size in use, held to 1..MAX_NOTES
    function automatic logic [IDX_W:0] eff_size(input logic [SIZE_W-1:0] s);
        logic [IDX_W:0] n;
        if (s == '0)
            n = (IDX_W+1)'(1);
        else if (int'(s) > MAX_NOTES)
            n = (IDX_W+1)'(MAX_NOTES);
        else
            n = (IDX_W+1)'(s);
        return n;
    endfunction

    // stored index held below the size in use
    function automatic logic [IDX_W-1:0] lim_index(input logic [IDX_W-1:0] i,
                                                   input logic [IDX_W:0]   n);
        logic [IDX_W:0] top;
        top = n - (IDX_W+1)'(1);
        return ({1'b0, i} >= n) ? top[IDX_W-1:0] : i;
    endfunction

    // incoming note to table index, clamped to the alphabet
    function automatic logic [IDX_W-1:0] note_to_index(input logic [NOTE_W-1:0] note,
                                                       input logic [OFS_W-1:0]  ofs,
                                                       input logic [IDX_W:0]    n);
        logic [NOTE_W:0] diff;
        logic [IDX_W:0]  top;
        logic [IDX_W-1:0] res;
        diff = {1'b0, note} - (NOTE_W+1)'(ofs);
        top  = n - (IDX_W+1)'(1);
        if (note < NOTE_W'(ofs))
            res = '0;
        else if (diff >= (NOTE_W+1)'(n))
            res = top[IDX_W-1:0];
        else
            res = diff[IDX_W-1:0];
        return res;
    endfunction

    // random index: (r * n) >> RAND_BITS
    function automatic logic [IDX_W-1:0] rand_index(input logic [RAND_BITS-1:0] r,
                                                    input logic [IDX_W:0]     n);
        logic [RAND_BITS+IDX_W:0] p;
        p = (RAND_BITS+IDX_W+1)'(r) * (RAND_BITS+IDX_W+1)'(n);
        return p[RAND_BITS +: IDX_W];
    endfunction

endpackage

FILE: rtl/second_order_markov_note_generator_unit.sv
// ----------------------------------------------------------------------------
// second_order_markov_note_generator_unit
// Learns note-to-note transition counts over a two-note history and samples
// the next note from them.
// ----------------------------------------------------------------------------
// Pulse start with a word on the input ports while busy is low. A clear
// command, a write to alphabet_size and reset each start a clearing pass over
// the count memory of 4096 entries (one entry a cycle), during which busy is
// high; configuration writes are still taken then. A recorded note keeps busy
// high for the read and write back of its count and history total once
// two notes of history exist, and leaves it low before that. A pick keeps busy
// high through setup, the total read and threshold multiply, the threshold,
// then one count read from the count memory per cycle, until the cumulative
// count reaches the threshold or the last note of the alphabet is read.
// The result word appears on generated_note, with done high for a single
// cycle; the receiver cannot stall it.
module second_order_markov_note_generator_unit
    import smng_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 start,
    output logic                 busy,
    input  logic [KIND_W-1:0]    kind,
    input  logic [NOTE_W-1:0]    note_value,
    input  logic [RAND_BITS-1:0] rand_pick,
    input  logic [RAND_BITS-1:0] rand_prev,
    input  logic [RAND_BITS-1:0] rand_prev2,
    output logic                 done,
    output logic [NOTE_W-1:0]    generated_note
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_LRD,
        S_LWR,
        S_PSETUP,
        S_PTOT,
        S_PMUL,
        S_PTHR,
        S_PSCAN
    } state_t;

    state_t                    state_reg;
    logic [OFS_W-1:0]          offset_reg;
    logic [SIZE_W-1:0]         size_reg;
    logic                      mode_reg;
    logic [IDX_W-1:0]          last_reg;
    logic [IDX_W-1:0]          earlier_reg;
    logic [1:0]                fill_reg;
    logic [CNT_AW-1:0]         clr_reg;
    logic [RAND_BITS-1:0]      pick_r_reg;
    logic [RAND_BITS-1:0]      prev_r_reg;
    logic [RAND_BITS-1:0]      prev2_r_reg;
    logic [HIST_W-1:0]         hist_reg;
    logic [IDX_W-1:0]          idx_reg;
    logic [RAND_BITS+CNT_W-1:0] prod_reg;
    logic [CNT_W-1:0]          thr_reg;
    logic [CNT_W-1:0]          cum_reg;
    logic [IDX_W-1:0]          rk_reg;
    logic [IDX_W-1:0]          ck_reg;
    logic                      cvalid_reg;
    logic                      done_reg;
    logic [NOTE_W-1:0]         note_out_reg;

    // state memories
    logic [CNT_W-1:0] cnt_mem [0:(1<<CNT_AW)-1];
    logic [CNT_W-1:0] tot_mem [0:(1<<HIST_W)-1];
    logic [CNT_W-1:0] cnt_rdata_reg;
    logic [CNT_W-1:0] tot_rdata_reg;

    logic [CNT_AW-1:0] cnt_addr;
    logic              cnt_we;
    logic              cnt_re;
    logic [CNT_W-1:0]  cnt_wdata;
    logic [HIST_W-1:0] tot_addr;
    logic              tot_we;
    logic              tot_re;
    logic [CNT_W-1:0]  tot_wdata;

    logic [IDX_W:0]    n_eff;
    logic [IDX_W:0]    n_top;
    logic [IDX_W-1:0]  note_idx;
    logic [IDX_W-1:0]  pick_e;
    logic [IDX_W-1:0]  pick_l;
    logic [CNT_W:0]    scan_sum;
    logic              scan_hit;
    logic [RAND_BITS+CNT_W:0] thr_sum;

    // index helpers
    assign n_eff    = eff_size(size_reg);
    assign n_top    = n_eff - (IDX_W+1)'(1);
    assign note_idx = note_to_index(note_value, offset_reg, n_eff);

    // history used for a pick, random where it is short
    always_comb
    begin
        if (fill_reg == 2'd0)
        begin
            pick_e = rand_index(prev2_r_reg, n_eff);
            pick_l = rand_index(prev_r_reg, n_eff);
        end
        else if (fill_reg == 2'd1)
        begin
            pick_e = lim_index(earlier_reg, n_eff);
            pick_l = rand_index(prev_r_reg, n_eff);
        end
        else
        begin
            pick_e = lim_index(earlier_reg, n_eff);
            pick_l = lim_index(last_reg, n_eff);
        end
    end

    // cumulative scan compare and rounded-up threshold
    assign scan_sum = {1'b0, cum_reg} + {1'b0, cnt_rdata_reg};
    assign scan_hit = (scan_sum >= {1'b0, thr_reg}) || ({1'b0, ck_reg} == n_top);
    assign thr_sum  = {1'b0, prod_reg} + (RAND_BITS+CNT_W+1)'((1 << RAND_BITS) - 1);

    // memory port control
    always_comb
    begin
        cnt_addr  = {hist_reg, idx_reg};
        cnt_we    = 1'b0;
        cnt_re    = 1'b0;
        cnt_wdata = cnt_rdata_reg + CNT_W'(1);
        tot_addr  = hist_reg;
        tot_we    = 1'b0;
        tot_re    = 1'b0;
        tot_wdata = tot_rdata_reg + CNT_W'(1);
        unique case (state_reg)
            S_CLEAR:
            begin
                cnt_addr  = clr_reg;
                cnt_we    = 1'b1;
                cnt_wdata = '0;
                tot_addr  = clr_reg[HIST_W-1:0];
                tot_we    = 1'b1;
                tot_wdata = '0;
            end
            S_LRD:
            begin
                cnt_re = 1'b1;
                tot_re = 1'b1;
            end
            S_LWR:
            begin
                cnt_we = (tot_rdata_reg != CNT_MAX);
                tot_we = (tot_rdata_reg != CNT_MAX);
            end
            S_PTOT:
            begin
                tot_re = 1'b1;
            end
            S_PSCAN:
            begin
                cnt_addr = {hist_reg, rk_reg};
                cnt_re   = 1'b1;
            end
            default:
            begin
                cnt_we = 1'b0;
            end
        endcase
    end

    // count memory
    always_ff @(posedge clk)
    begin
        if (cnt_we)
            cnt_mem[cnt_addr] <= cnt_wdata;
        if (cnt_re)
            cnt_rdata_reg <= cnt_mem[cnt_addr];
    end

    // history total memory
    always_ff @(posedge clk)
    begin
        if (tot_we)
            tot_mem[tot_addr] <= tot_wdata;
        if (tot_re)
            tot_rdata_reg <= tot_mem[tot_addr];
    end

    // sequencer, history and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            offset_reg   <= '0;
            size_reg     <= SIZE_W'(12);
            mode_reg     <= 1'b0;
            last_reg     <= '0;
            earlier_reg  <= '0;
            fill_reg     <= 2'd0;
            clr_reg      <= '0;
            pick_r_reg   <= '0;
            prev_r_reg   <= '0;
            prev2_r_reg  <= '0;
            hist_reg     <= '0;
            idx_reg      <= '0;
            prod_reg     <= '0;
            thr_reg      <= '0;
            cum_reg      <= '0;
            rk_reg       <= '0;
            ck_reg       <= '0;
            cvalid_reg   <= 1'b0;
            done_reg     <= 1'b0;
            note_out_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        pick_r_reg  <= rand_pick;
                        prev_r_reg  <= rand_prev;
                        prev2_r_reg <= rand_prev2;
                        case (kind)
                            KIND_CLEAR:
                            begin
                                state_reg   <= S_CLEAR;
                                clr_reg     <= '0;
                                last_reg    <= '0;
                                earlier_reg <= '0;
                                fill_reg    <= 2'd0;
                            end
                            KIND_NOTE:
                            begin
                                earlier_reg <= last_reg;
                                last_reg    <= note_idx;
                                if (mode_reg)
                                begin
                                    hist_reg <= {lim_index(earlier_reg, n_eff),
                                                 lim_index(last_reg, n_eff)};
                                    idx_reg  <= note_idx;
                                    if (fill_reg == 2'd2)
                                        state_reg <= S_LRD;
                                    else
                                        fill_reg <= fill_reg + 2'd1;
                                end
                                else
                                begin
                                    state_reg <= S_PSETUP;
                                end
                            end
                            KIND_GEN:
                            begin
                                if (!mode_reg)
                                    state_reg <= S_PSETUP;
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + CNT_AW'(1);
                    if (clr_reg == '1)
                        state_reg <= S_IDLE;
                end
                S_LRD:
                begin
                    state_reg <= S_LWR;
                end
                S_LWR:
                begin
                    state_reg <= S_IDLE;
                end
                S_PSETUP:
                begin
                    hist_reg    <= {pick_e, pick_l};
                    earlier_reg <= pick_l;
                    state_reg   <= S_PTOT;
                end
                S_PTOT:
                begin
                    state_reg <= S_PMUL;
                end
                S_PMUL:
                begin
                    prod_reg  <= (RAND_BITS+CNT_W)'(pick_r_reg) *
                                 (RAND_BITS+CNT_W)'(tot_rdata_reg);
                    state_reg <= S_PTHR;
                end
                S_PTHR:
                begin
                    thr_reg    <= thr_sum[RAND_BITS +: CNT_W];
                    cum_reg    <= '0;
                    rk_reg     <= '0;
                    cvalid_reg <= 1'b0;
                    state_reg  <= S_PSCAN;
                end
                S_PSCAN:
                begin
                    rk_reg     <= rk_reg + IDX_W'(1);
                    ck_reg     <= rk_reg;
                    cvalid_reg <= 1'b1;
                    if (cvalid_reg)
                    begin
                        if (scan_hit)
                        begin
                            last_reg     <= ck_reg;
                            fill_reg     <= 2'd2;
                            done_reg     <= 1'b1;
                            note_out_reg <= NOTE_W'(offset_reg) + NOTE_W'(ck_reg);
                            state_reg    <= S_IDLE;
                        end
                        else
                        begin
                            cum_reg <= scan_sum[CNT_W-1:0];
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            // register writes
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_OFFSET:
                    begin
                        offset_reg <= cfg_data[OFS_W-1:0];
                    end
                    REG_SIZE:
                    begin
                        size_reg    <= cfg_data[SIZE_W-1:0];
                        state_reg   <= S_CLEAR;
                        clr_reg     <= '0;
                        last_reg    <= '0;
                        earlier_reg <= '0;
                        fill_reg    <= 2'd0;
                    end
                    REG_MODE:
                    begin
                        mode_reg <= cfg_data[0];
                    end
                    default:
                    begin
                        mode_reg <= mode_reg;
                    end
                endcase
            end
        end
    end

    assign busy           = (state_reg != S_IDLE);
    assign done           = done_reg;
    assign generated_note = note_out_reg;

    // checks
    a_done_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == S_PSCAN))
        else $error("result word without a finished scan");

    a_cnt_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_we |-> (state_reg == S_CLEAR || state_reg == S_LWR))
        else $error("count memory written outside clear or learn");

    a_lwr_after_lrd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LWR) |-> $past(state_reg == S_LRD))
        else $error("write back without a prior read");

    a_size_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_we && cfg_index == REG_SIZE) |=> (state_reg == S_CLEAR))
        else $error("size write did not start a clearing pass");

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg != 2'd3)
        else $error("history fill out of range");

endmodule
